>>> design/cvt_pkg.sv
// Shared types, codes and default sizes for the compacting value table.
package cvt_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_APPEND = 3'd0;
    localparam op_t OP_DELETE = 3'd1;
    localparam op_t OP_READ   = 3'd2;
    localparam op_t OP_WRITE  = 3'd3;
    localparam op_t OP_SEARCH = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_RANGE     = 2'd3;

    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  read_value;
        logic [INDEX_W-1:0] found_index;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    // Operation held for the duration of a trip down the cell chain.
    typedef struct packed {
        logic is_delete;
        logic is_search;
        logic is_read;
    } bcast_t;

    // Control part of the token that walks the cell chain.
    typedef struct packed {
        logic active;
        logic found;
    } tok_t;

endpackage

>>> design/cvt_cell.sv
// One storage cell of the table chain: holds one entry and processes the passing token.
module cvt_cell #(
    parameter int VW  = 32,
    parameter int IW  = 6,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cvt_pkg::bcast_t bc,
    input  logic [VW-1:0]   key,
    input  logic [IW-1:0]   ridx,
    input  logic [CW-1:0]   cnt,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_idx,
    input  logic [VW-1:0]   wr_data,
    input  logic [VW-1:0]   right_data,
    output logic [VW-1:0]   data,
    input  cvt_pkg::tok_t   tok_in,
    input  logic [IW-1:0]   fidx_in,
    input  logic [VW-1:0]   rd_in,
    output cvt_pkg::tok_t   tok_out,
    output logic [IW-1:0]   fidx_out,
    output logic [VW-1:0]   rd_out
);
    import cvt_pkg::*;

    localparam logic [CW-1:0] MY_CNT = CW'(IDX);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [VW-1:0] data_reg, data_next;
    tok_t          tok_reg, tok_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [VW-1:0] rd_reg, rd_next;
    logic          in_range, hit_here, shift, rd_hit;

    always_comb
    begin
        in_range = MY_CNT < cnt;
        hit_here = tok_in.active && in_range && !tok_in.found
                   && (bc.is_delete || bc.is_search) && (data_reg == key);
        // Once the first match is at or before this cell, a delete pulls the
        // right neighbor's entry in, which closes the gap.
        shift    = tok_in.active && bc.is_delete && in_range
                   && (tok_in.found || hit_here);
        rd_hit   = tok_in.active && bc.is_read && (ridx == MY_IDX);

        if (wr_en && (wr_idx == MY_IDX))
            data_next = wr_data;
        else if (shift)
            data_next = right_data;
        else
            data_next = data_reg;

        tok_next.active = tok_in.active;
        tok_next.found  = tok_in.active && (tok_in.found || hit_here);
        fidx_next       = hit_here ? MY_IDX : fidx_in;
        rd_next         = rd_hit ? data_reg : rd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        fidx_reg <= fidx_next;
        rd_reg   <= rd_next;
    end

    assign data     = data_reg;
    assign tok_out  = tok_reg;
    assign fidx_out = fidx_reg;
    assign rd_out   = rd_reg;

endmodule

>>> design/compacting_value_table_unit.sv
// Top level of the compacting value table: request decode, count and the cell chain.
//
// The table holds an ordered list of up to DEPTH values and an entry count.
// A transaction is taken at a rising edge where start is high and busy is
// low; its result appears on rsp for exactly one cycle with done high, and
// the receiver cannot stall it. Append, write, an out-of-range read and an
// undefined op are settled at once: the result shows in the cycle after the
// transaction and another transaction may be taken in that same cycle, so
// these run one per cycle. Search, delete and an in-range read send a token
// down the chain of DEPTH cells, one cell per cycle, through the launch
// register and each cell's token register in order to the done and rsp
// registers. Busy stays high until the result shows, and the next
// transaction can be taken once it has shown. On delete, every cell at or
// after the first match and below the count copies its right neighbor's
// entry as the token passes, so the list is compacted during the same walk.
// Entries carry no reset; only positions below the count are ever returned.
module compacting_value_table_unit #(
    parameter int DEPTH       = cvt_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = cvt_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cvt_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output cvt_pkg::rsp_t rsp
);
    import cvt_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Count and control state.
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;
    tok_t          launch_reg, launch_next;

    // Operation held while the token walks the chain.
    bcast_t        bc_reg;
    logic [VW-1:0] key_reg;
    logic [IW-1:0] ridx_reg;

    // Decode of the incoming transaction.
    logic          accept;
    logic [VW-1:0] key_in;
    logic [IW-1:0] idx_in;
    logic          in_range;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          go_chain;
    logic          imm;
    rsp_t          imm_rsp;
    logic [CW-1:0] imm_cnt;
    bcast_t        bc_in;

    // Width adapters between the fixed transaction fields and the sizes set
    // by the parameters.
    logic [VW+DATA_W-1:0]  key_ext;
    logic [IW+INDEX_W-1:0] idx_ext;
    logic [CW+INDEX_W-1:0] idx_cmp;
    logic [CW+INDEX_W-1:0] cnt_cmp;
    logic [COUNT_W+CW-1:0] cnt_out_ext;
    logic [COUNT_W+CW-1:0] cnt_dec_ext;

    // Chain wiring; index DEPTH of the token arrays is the end of the chain.
    logic [VW-1:0] data_w [DEPTH];
    tok_t          tok_w  [DEPTH+1];
    logic [IW-1:0] fidx_w [DEPTH+1];
    logic [VW-1:0] rd_w   [DEPTH+1];

    logic [DATA_W+VW-1:0]  rd_out_ext;
    logic [INDEX_W+IW-1:0] fidx_out_ext;

    assign accept  = start && !busy_reg;
    assign key_ext = {{VW{1'b0}}, req.value};
    assign key_in  = key_ext[VW-1:0];
    assign idx_ext = {{IW{1'b0}}, req.index};
    assign idx_in  = idx_ext[IW-1:0];
    assign idx_cmp = {{CW{1'b0}}, req.index};
    assign cnt_cmp = {{INDEX_W{1'b0}}, cnt_reg};
    assign in_range = idx_cmp < cnt_cmp;

    // Settle what can be settled at once; the rest goes down the chain.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = idx_in;
        go_chain = 1'b0;
        imm      = 1'b0;
        imm_cnt  = cnt_reg;
        bc_in    = '0;
        imm_rsp.status      = ST_OK;
        imm_rsp.read_value  = '0;
        imm_rsp.found_index = '0;
        unique case (req.op)
            OP_APPEND:
            begin
                imm = 1'b1;
                if (cnt_reg == FULL_CNT)
                begin
                    imm_rsp.status = ST_FULL;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_idx  = cnt_reg[IW-1:0];
                    imm_cnt = cnt_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                go_chain        = 1'b1;
                bc_in.is_delete = 1'b1;
            end
            OP_SEARCH:
            begin
                go_chain        = 1'b1;
                bc_in.is_search = 1'b1;
            end
            OP_READ:
            begin
                if (in_range)
                begin
                    go_chain      = 1'b1;
                    bc_in.is_read = 1'b1;
                end
                else
                begin
                    imm            = 1'b1;
                    imm_rsp.status = ST_RANGE;
                end
            end
            OP_WRITE:
            begin
                imm = 1'b1;
                if (in_range)
                    wr_en = 1'b1;
                else
                    imm_rsp.status = ST_RANGE;
            end
            default:
            begin
                imm = 1'b1;
            end
        endcase
        cnt_out_ext = {{COUNT_W{1'b0}}, imm_cnt};
        imm_rsp.entry_count = cnt_out_ext[COUNT_W-1:0];
    end

    // Chain of cells. The last cell's right neighbor is itself; what it
    // holds after a delete lies past the count and is never returned.
    assign tok_w[0]  = launch_reg;
    assign fidx_w[0] = '0;
    assign rd_w[0]   = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cvt_cell #(
            .VW  (VW),
            .IW  (IW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .bc         (bc_reg),
            .key        (key_reg),
            .ridx       (ridx_reg),
            .cnt        (cnt_reg),
            .wr_en      (wr_en && accept),
            .wr_idx     (wr_idx),
            .wr_data    (key_in),
            .right_data (data_w[(i + 1 < DEPTH) ? i + 1 : i]),
            .data       (data_w[i]),
            .tok_in     (tok_w[i]),
            .fidx_in    (fidx_w[i]),
            .rd_in      (rd_w[i]),
            .tok_out    (tok_w[i+1]),
            .fidx_out   (fidx_w[i+1]),
            .rd_out     (rd_w[i+1])
        );
    end

    assign rd_out_ext   = {{DATA_W{1'b0}}, rd_w[DEPTH]};
    assign fidx_out_ext = {{INDEX_W{1'b0}}, fidx_w[DEPTH]};

    // Next state for count, busy, launch and the result register.
    always_comb
    begin
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        launch_next = '0;
        cnt_dec_ext = {{COUNT_W{1'b0}}, cnt_reg};

        if (accept && imm)
        begin
            cnt_next  = imm_cnt;
            done_next = 1'b1;
            rsp_next  = imm_rsp;
        end
        else if (accept && go_chain)
        begin
            busy_next          = 1'b1;
            launch_next.active = 1'b1;
        end

        // The token leaving the last cell closes a chain transaction.
        if (tok_w[DEPTH].active)
        begin
            busy_next            = 1'b0;
            done_next            = 1'b1;
            rsp_next.status      = ST_OK;
            rsp_next.read_value  = '0;
            rsp_next.found_index = '0;
            if (bc_reg.is_read)
            begin
                rsp_next.read_value = rd_out_ext[DATA_W-1:0];
            end
            else if (tok_w[DEPTH].found)
            begin
                rsp_next.found_index = fidx_out_ext[INDEX_W-1:0];
                if (bc_reg.is_delete)
                begin
                    cnt_next    = cnt_reg - CW'(1);
                    cnt_dec_ext = {{COUNT_W{1'b0}}, cnt_next};
                end
            end
            else
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
            rsp_next.entry_count = cnt_dec_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            launch_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            launch_reg <= launch_next;
        end
    end

    // Payload registers; the held operation is loaded only when a chain
    // transaction starts.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept && go_chain)
        begin
            bc_reg   <= bc_in;
            key_reg  <= key_in;
            ridx_reg <= idx_in;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> design/cvt_checker.sv
// Port-level assertions for the compacting value table and their bind to the top level.
module cvt_checker #(
    parameter int DEPTH = cvt_pkg::DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input cvt_pkg::req_t req,
    input logic          busy,
    input logic          done,
    input cvt_pkg::rsp_t rsp
);
    import cvt_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // Append, write and undefined ops answer in the next cycle without busy.
    a_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.op == OP_APPEND || req.op == OP_WRITE
                            || req.op > OP_SEARCH))
        |=> (done && !busy))
        else $error("immediate transaction did not answer in the next cycle");

    // Search and delete always walk the chain.
    a_chain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.op == OP_DELETE || req.op == OP_SEARCH))
        |=> (busy && !done))
        else $error("search or delete did not raise busy");

    // Busy ends exactly when the chain result is shown.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // A full status only occurs with the table at its depth.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.entry_count == FULL_COUNT))
        else $error("full status with count below depth");

    // A failed transaction returns no data and no position.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.read_value == '0 && rsp.found_index == '0))
        else $error("failed transaction returned data or position");

endmodule

bind compacting_value_table_unit cvt_checker #(.DEPTH(DEPTH)) u_cvt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

>>> tb/tb_compacting_value_table_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the compacting value table unit.

module tb_compacting_value_table_unit;

    import cvt_pkg::*;

    // The table is built at its default size, so the predictor uses the same one.
    localparam int DEPTH = DEPTH_DEF;

    // Ops five to seven are not decoded by the block; they must leave it untouched.
    localparam op_t OP_FIRST_UNUSED = 3'd5;
    localparam op_t OP_LAST_UNUSED  = 3'd7;

    // The slowest transaction walks the whole chain; even for around 950 items,
    // each with the longest sender gap, this limit leaves a wide margin.
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = DEPTH + 4;
    localparam int MAX_GAP = 6;

    // Every accepted transaction is queued with the response it must produce.
    typedef struct packed {
        req_t cmd;
        rsp_t want;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic start;
    req_t req_bus;
    logic busy;
    logic done;
    rsp_t rsp_bus;

    // Shadow copy of the table: the stored values and the number of live entries.
    logic [DATA_W-1:0] table_vals [DEPTH];
    int                table_count;

    outcome_t outcome_q[$];
    int       mismatches;
    int       cycles;
    int       idle_pct;

    compacting_value_table_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req_bus),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Applies one request to the shadow table and returns the response that the
    // block must give for it. Only positions below the count are ever touched.
    function automatic rsp_t table_apply(input req_t r);
        rsp_t o;
        int   hit;
        int   k;
        o   = '0;
        hit = -1;
        if (r.op == OP_DELETE || r.op == OP_SEARCH)
        begin
            for (k = 0; k < table_count; k++)
            begin
                if (hit < 0 && table_vals[k] == r.value)
                    hit = k;
            end
        end
        case (r.op)
            OP_APPEND:
            begin
                if (table_count >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    table_vals[table_count] = r.value;
                    table_count++;
                end
            end
            OP_DELETE:
            begin
                if (hit < 0)
                    o.status = ST_NOT_FOUND;
                else
                begin
                    // Later entries close the gap left by the removed one.
                    for (k = hit + 1; k < table_count; k++)
                        table_vals[k - 1] = table_vals[k];
                    table_count--;
                    o.found_index = INDEX_W'(hit);
                end
            end
            OP_READ:
            begin
                if (r.index < table_count)
                    o.read_value = table_vals[r.index];
                else
                    o.status = ST_RANGE;
            end
            OP_WRITE:
            begin
                if (r.index < table_count)
                    table_vals[r.index] = r.value;
                else
                    o.status = ST_RANGE;
            end
            OP_SEARCH:
            begin
                if (hit < 0)
                    o.status = ST_NOT_FOUND;
                else
                    o.found_index = INDEX_W'(hit);
            end
            default:
            begin
            end
        endcase
        o.entry_count = COUNT_W'(table_count);
        return o;
    endfunction

    function automatic req_t make_req(input op_t op, input logic [DATA_W-1:0] value,
                                      input logic [INDEX_W-1:0] index);
        req_t r;
        r.op    = op;
        r.value = value;
        r.index = index;
        return r;
    endfunction

    // Builds a random request. Most searches and deletes look for a value that
    // is in the table, and some values come from a tiny pool so that duplicates
    // appear; most reads and writes aim inside the live range.
    function automatic req_t random_request(input int append_w, input int delete_w);
        req_t r;
        int   pick;
        r.value = $urandom;
        r.index = INDEX_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < append_w)
            r.op = OP_APPEND;
        else if (pick < append_w + delete_w)
            r.op = OP_DELETE;
        else if (pick < 96)
        begin
            case (pick % 3)
                0:       r.op = OP_READ;
                1:       r.op = OP_WRITE;
                default: r.op = OP_SEARCH;
            endcase
        end
        else
            r.op = op_t'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        pick = $urandom_range(0, 99);
        if ((r.op == OP_DELETE || r.op == OP_SEARCH) && table_count > 0 && pick < 70)
            r.value = table_vals[$urandom_range(0, table_count - 1)];
        else if (pick >= 80)
            r.value = DATA_W'($urandom_range(0, 3));
        if ((r.op == OP_READ || r.op == OP_WRITE) && table_count > 0
            && $urandom_range(0, 99) < 85)
            r.index = INDEX_W'($urandom_range(0, table_count - 1));
        return r;
    endfunction

    // Sends one transaction. Inputs change on the falling edge; the transaction
    // counts as taken at the first rising edge where busy is low, which is also
    // where its expected response is worked out. The task returns on the next
    // falling edge, so start is never lowered and raised in the same step.
    task automatic send_request(input req_t r);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, MAX_GAP) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        req_bus <= r;
        do
            @(posedge clk);
        while (busy);
        outcome_q.push_back('{cmd: r, want: table_apply(r)});
        @(negedge clk);
    endtask

    // Holds the sender off until every queued response has come back, then lets
    // a chain walk's worth of cycles pass in case anything stray shows up.
    task automatic drain_results();
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Every op but append on an empty table, including the undecoded ones, with
    // extreme values and indexes.
    task automatic test_empty_table();
        send_request(make_req(OP_READ,   '0, '0));
        send_request(make_req(OP_WRITE,  '1, '1));
        send_request(make_req(OP_SEARCH, '0, '0));
        send_request(make_req(OP_DELETE, '0, '0));
        send_request(make_req(OP_FIRST_UNUSED, '0, '0));
        send_request(make_req(op_t'(OP_FIRST_UNUSED + 3'd1), '1, '1));
        send_request(make_req(OP_LAST_UNUSED, 32'h5A5A_A5A5, 6'd21));
    endtask

    // A short hand-built sequence: duplicates, delete of the first match, the
    // last entry and the only entry, a read just past the end, and a write and a read far past it.
    task automatic test_basic_ops();
        send_request(make_req(OP_APPEND, '0, '0));
        send_request(make_req(OP_APPEND, '1, '0));
        send_request(make_req(OP_APPEND, '0, '0));
        send_request(make_req(OP_APPEND, 32'h8000_0001, '0));
        send_request(make_req(OP_READ,   '0, 6'd3));
        send_request(make_req(OP_READ,   '0, 6'd4));
        send_request(make_req(OP_SEARCH, '0, '0));
        send_request(make_req(OP_SEARCH, '1, '0));
        send_request(make_req(OP_DELETE, '0, '0));
        send_request(make_req(OP_SEARCH, '0, '0));
        send_request(make_req(OP_WRITE,  32'h7FFF_FFFE, 6'd2));
        send_request(make_req(OP_READ,   '0, 6'd2));
        send_request(make_req(OP_DELETE, 32'h7FFF_FFFE, '0));
        send_request(make_req(OP_WRITE,  '0, '1));
        send_request(make_req(OP_READ,   '0, '1));
        send_request(make_req(OP_DELETE, '1, '0));
        send_request(make_req(OP_DELETE, '0, '0));
        send_request(make_req(OP_DELETE, '0, '0));
    endtask

    // Fills the table to the top back to back, then pushes against the full
    // limit and works on the last slot.
    task automatic test_fill_to_full();
        while (table_count < DEPTH)
        begin
            if ($urandom_range(0, 99) < 85)
                send_request(make_req(OP_APPEND, $urandom, '0));
            else
                send_request(random_request(0, 0));
        end
        send_request(make_req(OP_APPEND, '1, '0));
        send_request(make_req(OP_APPEND, '0, '0));
        send_request(make_req(OP_READ,   '0, '1));
        send_request(make_req(OP_SEARCH, table_vals[DEPTH - 1], '0));
        send_request(make_req(OP_WRITE,  '1, '1));
        send_request(make_req(OP_SEARCH, '1, '0));
        send_request(make_req(OP_DELETE, table_vals[0], '0));
        send_request(make_req(OP_APPEND, 32'h0BAD_F00D, '0));
        send_request(make_req(OP_APPEND, 32'h0BAD_F00D, '0));
    endtask

    // Random traffic; the weights steer the count up or down so that both the
    // full and the empty ends of the table are visited. Undecoded ops are sent
    // but not counted, since the block ignores them.
    task automatic test_random_traffic(input int n, input int append_w, input int delete_w);
        req_t r;
        int   sent;
        sent = 0;
        while (sent < n)
        begin
            r = random_request(append_w, delete_w);
            send_request(r);
            if (r.op <= OP_SEARCH)
                sent++;
        end
    endtask

    // Response checker: each strobe takes the oldest expectation and compares
    // every field. A strobe with nothing queued is an error too.
    always @(posedge clk)
    begin
        outcome_t head;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response at cycle %0d: status %0d data %h idx %0d cnt %0d",
                             cycles, rsp_bus.status, rsp_bus.read_value,
                             rsp_bus.found_index, rsp_bus.entry_count);
            end
            else
            begin
                head = outcome_q.pop_front();
                if (rsp_bus.status != head.want.status
                    || rsp_bus.read_value != head.want.read_value
                    || rsp_bus.found_index != head.want.found_index
                    || rsp_bus.entry_count != head.want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch op %0d value %h index %0d: expected %0d/%h/%0d/%0d, got %0d/%h/%0d/%0d",
                                 head.cmd.op, head.cmd.value, head.cmd.index,
                                 head.want.status, head.want.read_value,
                                 head.want.found_index, head.want.entry_count,
                                 rsp_bus.status, rsp_bus.read_value,
                                 rsp_bus.found_index, rsp_bus.entry_count);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_bus     = '0;
        table_count = 0;
        mismatches  = 0;
        cycles      = 0;
        idle_pct    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, back to back.
        test_empty_table();
        test_basic_ops();
        drain_results();

        // The table is filled with no sender gaps, then the mix runs through
        // the sender idling phases. One phase drains the table back down.
        test_fill_to_full();
        idle_pct = 67;
        test_random_traffic(200, 30, 25);
        drain_results();
        idle_pct = 0;
        test_random_traffic(200, 10, 50);
        idle_pct = 26;
        test_random_traffic(200, 45, 15);
        idle_pct = 0;
        test_random_traffic(200, 30, 30);

        drain_results();
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
